// ===== hw/rtl/joystick_axis_and_button_qualifier_top_macros.svh =====
// Assertion macros for the qualifier top-level RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef JOYSTICK_AXIS_AND_BUTTON_QUALIFIER_TOP_MACROS_SVH
`define JOYSTICK_AXIS_AND_BUTTON_QUALIFIER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define JABQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jabq: same-cycle check failed");

// Next-cycle implication
`define JABQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jabq: next-cycle check failed");

`else

`define JABQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define JABQ_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/jabq_pkg.sv =====
package jabq_pkg;

   // Configuration field widths
   localparam int CENTER_BITS = 12;
   localparam int THR_BITS    = 11;
   localparam int MS_BITS     = 16;
   localparam int TIME_BITS   = 32;

   // Axis zone; doubles as the direction event code (centre = no event)
   typedef enum logic [1:0] {
      ZONE_CENTRE = 2'd0,
      ZONE_UP     = 2'd1,
      ZONE_DOWN   = 2'd2
   } zone_type;

   // Configuration register set
   typedef struct packed {
      logic [CENTER_BITS-1:0] center_level;
      logic [THR_BITS-1:0]    enter_threshold;
      logic [THR_BITS-1:0]    return_threshold;
      logic                   invert_axis;
      logic [MS_BITS-1:0]     edge_hold_ms;
      logic [MS_BITS-1:0]     repeat_period_ms;
      logic [MS_BITS-1:0]     long_press_ms;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic       long_press;
      logic       short_press;
      zone_type   direction_event;
   } result_type;

endpackage

// ===== hw/rtl/jabq_eval.sv =====
// Per-tick evaluation: axis zone with hysteresis, hold and auto-repeat
// timing, button short/long press. State advances only on step.
module jabq_eval
   import jabq_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  cfg_type                cfg,
   input  logic [SAMPLE_BITS-1:0] axis_sample,
   input  logic                   button_down,
   input  logic [TIME_BITS-1:0]   now_ms,
   output result_type             result
);

   // Signed width holding both the deflection and a negated threshold
   localparam int DW = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;

   zone_type               zone_ff, zone_in;
   logic [TIME_BITS-1:0]   zone_entered_at_ff, zone_entered_at_in;
   logic                   first_event_done_ff, first_event_done_in;
   logic [TIME_BITS-1:0]   last_event_at_ff, last_event_at_in;
   logic                   button_held_ff, button_held_in;
   logic [TIME_BITS-1:0]   button_pressed_at_ff, button_pressed_at_in;
   logic                   long_done_ff, long_done_in;

   logic [SAMPLE_BITS-1:0] center;
   logic signed [DW-1:0]   dev_raw;
   logic signed [DW-1:0]   dev;
   logic signed [DW-1:0]   thr;
   logic [THR_BITS-1:0]    thr_sel;
   zone_type               zone_now;
   logic [TIME_BITS-1:0]   zone_age;
   logic [TIME_BITS-1:0]   repeat_age;
   logic [TIME_BITS-1:0]   press_age;
   zone_type               dir_evt;
   logic                   short_evt;
   logic                   long_evt;

   // Deflection from the rest value, optionally inverted
   assign center  = SAMPLE_BITS'(cfg.center_level);
   assign dev_raw = $signed(DW'(axis_sample)) - $signed(DW'(center));
   assign dev     = cfg.invert_axis ? -dev_raw : dev_raw;

   // Hysteresis: enter threshold in centre, return threshold while deflected
   assign thr_sel = (zone_ff == ZONE_CENTRE) ? cfg.enter_threshold : cfg.return_threshold;
   assign thr     = $signed(DW'(thr_sel));

   always_comb begin
      if (dev > thr) begin
         zone_now = ZONE_UP;
      end else if (dev < -thr) begin
         zone_now = ZONE_DOWN;
      end else begin
         zone_now = ZONE_CENTRE;
      end
   end

   // Direction events: first after the hold time, then periodic
   always_comb begin
      zone_in             = zone_now;
      zone_entered_at_in  = zone_entered_at_ff;
      first_event_done_in = first_event_done_ff;
      last_event_at_in    = last_event_at_ff;
      dir_evt             = ZONE_CENTRE;

      if (zone_now != zone_ff) begin
         zone_entered_at_in  = now_ms;
         first_event_done_in = 1'b0;
      end

      zone_age   = now_ms - zone_entered_at_in;
      repeat_age = now_ms - last_event_at_ff;

      if (zone_now != ZONE_CENTRE) begin
         if (!first_event_done_in) begin
            if (zone_age >= TIME_BITS'(cfg.edge_hold_ms)) begin
               dir_evt             = zone_now;
               first_event_done_in = 1'b1;
               last_event_at_in    = now_ms;
            end
         end else if (repeat_age >= TIME_BITS'(cfg.repeat_period_ms)) begin
            dir_evt          = zone_now;
            last_event_at_in = now_ms;
         end
      end
   end

   // Button: timing starts on press, long press once, short on release if no long press fired
   assign press_age = now_ms - button_pressed_at_ff;

   always_comb begin
      button_held_in       = button_held_ff;
      button_pressed_at_in = button_pressed_at_ff;
      long_done_in         = long_done_ff;
      short_evt            = 1'b0;
      long_evt             = 1'b0;

      if (button_down && !button_held_ff) begin
         button_held_in       = 1'b1;
         button_pressed_at_in = now_ms;
         long_done_in         = 1'b0;
      end else if (button_down && button_held_ff) begin
         if (!long_done_ff && press_age >= TIME_BITS'(cfg.long_press_ms)) begin
            long_evt     = 1'b1;
            long_done_in = 1'b1;
         end
      end else if (!button_down && button_held_ff) begin
         button_held_in = 1'b0;
         short_evt      = !long_done_ff;
      end
   end

   assign result = {long_evt, short_evt, dir_evt};

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff              <= ZONE_CENTRE;
         zone_entered_at_ff   <= '0;
         first_event_done_ff  <= 1'b0;
         last_event_at_ff     <= '0;
         button_held_ff       <= 1'b0;
         button_pressed_at_ff <= '0;
         long_done_ff         <= 1'b0;
      end else if (step) begin
         zone_ff              <= zone_in;
         zone_entered_at_ff   <= zone_entered_at_in;
         first_event_done_ff  <= first_event_done_in;
         last_event_at_ff     <= last_event_at_in;
         button_held_ff       <= button_held_in;
         button_pressed_at_ff <= button_pressed_at_in;
         long_done_ff         <= long_done_in;
      end
   end

endmodule

// ===== hw/rtl/joystick_axis_and_button_qualifier_top.sv =====
// Joystick axis and button qualifier.
// req_* stream: one tick per transfer (axis sample, button level, ms time).
// rsp_* stream: exactly one result per tick, in order: direction event
// (0 none, 1 up, 2 down), short press and long press, all one-tick pulses.
// csr_* channel: register index and data; always ready. Write only while
// no tick is in flight.
// A tick goes from the input register through the evaluation logic into
// the result register.
// Throughput: one tick per cycle while results are taken; all work is a few
// subtracts and compares, combinational between the input and result registers.
// When rsp_tready is low the result register holds; the input register
// still takes one more tick, after which req_tready drops until the result
// is taken.
// Reset (synchronous, active high) restores the register defaults, clears
// the zone and button tracking and empties both pipeline registers.
`include "joystick_axis_and_button_qualifier_top_macros.svh"
module joystick_axis_and_button_qualifier_top
   import jabq_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: axis_sample[SAMPLE_BITS-1:0], button_down, now_ms[31:0], zero pad
   input  logic [((SAMPLE_BITS+1+TIME_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: direction_event[1:0], short_press, long_press, zero pad
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [2:0]            csr_index,
   input  logic [MS_BITS-1:0]    csr_data,
   input  logic                  csr_valid,
   output logic                  csr_ready
);

   typedef enum logic [2:0] {
      REG_CENTER_LEVEL     = 3'd0,
      REG_ENTER_THRESHOLD  = 3'd1,
      REG_RETURN_THRESHOLD = 3'd2,
      REG_INVERT_AXIS      = 3'd3,
      REG_EDGE_HOLD        = 3'd4,
      REG_REPEAT_PERIOD    = 3'd5,
      REG_LONG_PRESS       = 3'd6
   } reg_index_type;

   cfg_type                cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_axis_ff;
   logic                   in_button_ff;
   logic [TIME_BITS-1:0]   in_now_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_result_ff;
   result_type             result;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   advance;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_CENTER_LEVEL:     cfg_in.center_level     = csr_data[CENTER_BITS-1:0];
            REG_ENTER_THRESHOLD:  cfg_in.enter_threshold  = csr_data[THR_BITS-1:0];
            REG_RETURN_THRESHOLD: cfg_in.return_threshold = csr_data[THR_BITS-1:0];
            REG_INVERT_AXIS:      cfg_in.invert_axis      = csr_data[0];
            REG_EDGE_HOLD:        cfg_in.edge_hold_ms     = csr_data;
            REG_REPEAT_PERIOD:    cfg_in.repeat_period_ms = csr_data;
            REG_LONG_PRESS:       cfg_in.long_press_ms    = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Pipeline handshake
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_xfer ? 1'b0 : out_valid_ff);

   jabq_eval #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_eval (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .cfg         (cfg_ff),
      .axis_sample (in_axis_ff),
      .button_down (in_button_ff),
      .now_ms      (in_now_ff),
      .result      (result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_level     <= CENTER_BITS'(2048);
         cfg_ff.enter_threshold  <= THR_BITS'(400);
         cfg_ff.return_threshold <= THR_BITS'(240);
         cfg_ff.invert_axis      <= 1'b0;
         cfg_ff.edge_hold_ms     <= MS_BITS'(50);
         cfg_ff.repeat_period_ms <= MS_BITS'(300);
         cfg_ff.long_press_ms    <= MS_BITS'(1000);
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_axis_ff   <= req_tdata[SAMPLE_BITS-1:0];
         in_button_ff <= req_tdata[SAMPLE_BITS];
         in_now_ff    <= req_tdata[SAMPLE_BITS+1 +: TIME_BITS];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.long_press, out_result_ff.short_press,
                        out_result_ff.direction_event};

   // Checks
   `JABQ_ASSERT_IMP(a_press_exclusive, clock, reset, rsp_tvalid, !(out_result_ff.long_press && out_result_ff.short_press))
   `JABQ_ASSERT_IMP(a_dir_code, clock, reset, rsp_tvalid, out_result_ff.direction_event != 2'd3)
   `JABQ_ASSERT_NXT(a_advance_fills, clock, reset, advance, out_valid_ff)
   `JABQ_ASSERT_NXT(a_stall_keeps, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_now_ff))

endmodule

// ===== tb/tb_joystick_axis_and_button_qualifier_top.sv =====
`timescale 1ns / 100ps

module tb_joystick_axis_and_button_qualifier_top;
   import jabq_pkg::*;

   localparam int SAMPLE_BITS    = 12;
   localparam int REQ_BITS       = ((SAMPLE_BITS + 1 + TIME_BITS + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_REPORTS    = 10;

   // Register map of the csr channel
   typedef enum logic [2:0] {
      REG_CENTER_LEVEL  = 3'd0,
      REG_ENTER_THR     = 3'd1,
      REG_RETURN_THR    = 3'd2,
      REG_INVERT        = 3'd3,
      REG_EDGE_HOLD     = 3'd4,
      REG_REPEAT_PERIOD = 3'd5,
      REG_LONG_PRESS    = 3'd6,
      REG_UNMAPPED      = 3'd7
   } csr_reg_type;

   logic                  clock;
   logic                  reset;
   logic [REQ_BITS-1:0]   req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2:0]            csr_index;
   logic [MS_BITS-1:0]    csr_data;
   logic                  csr_valid;
   logic                  csr_ready;

   // Shadow copy of the block's registers and tracking state
   cfg_type               cfg;
   zone_type              cur_zone;
   logic [TIME_BITS-1:0]  zone_t0;
   logic [TIME_BITS-1:0]  last_evt_t;
   logic [TIME_BITS-1:0]  press_t0;
   logic                  first_done;
   logic                  btn_held;
   logic                  long_fired;

   result_type            expected_results[$];
   int                    mismatch_count;
   int                    idle_cycles;
   int                    ready_hold;
   bit                    no_idle;
   bit                    run_done;
   logic [TIME_BITS-1:0]  now_ms_cur;

   joystick_axis_and_button_qualifier_top #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   task automatic reset_shadow();
      cfg.center_level     = 12'd2048;
      cfg.enter_threshold  = 11'd400;
      cfg.return_threshold = 11'd240;
      cfg.invert_axis      = 1'b0;
      cfg.edge_hold_ms     = 16'd50;
      cfg.repeat_period_ms = 16'd300;
      cfg.long_press_ms    = 16'd1000;
      cur_zone   = ZONE_CENTRE;
      zone_t0    = '0;
      last_evt_t = '0;
      press_t0   = '0;
      first_done = 1'b0;
      btn_held   = 1'b0;
      long_fired = 1'b0;
   endtask

   // Register write as the block sees it: unknown index ignored, high bits dropped
   task automatic shadow_write(logic [2:0] idx, logic [MS_BITS-1:0] data);
      case (idx)
         REG_CENTER_LEVEL:  cfg.center_level     = data[CENTER_BITS-1:0];
         REG_ENTER_THR:     cfg.enter_threshold  = data[THR_BITS-1:0];
         REG_RETURN_THR:    cfg.return_threshold = data[THR_BITS-1:0];
         REG_INVERT:        cfg.invert_axis      = data[0];
         REG_EDGE_HOLD:     cfg.edge_hold_ms     = data;
         REG_REPEAT_PERIOD: cfg.repeat_period_ms = data;
         REG_LONG_PRESS:    cfg.long_press_ms    = data;
         default: ;
      endcase
   endtask

   // One tick: zone with hysteresis, hold and repeat, then the button
   function automatic result_type qualify_tick(logic [SAMPLE_BITS-1:0] axis, logic btn,
                                               logic [TIME_BITS-1:0] now);
      result_type           res;
      zone_type             z;
      int                   defl;
      int                   thr;
      logic [TIME_BITS-1:0] elapsed;
      res  = '0;
      defl = int'(axis) - int'(cfg.center_level);
      if (cfg.invert_axis)
         defl = -defl;
      thr = (cur_zone == ZONE_CENTRE) ? int'(cfg.enter_threshold)
                                      : int'(cfg.return_threshold);
      if (defl > thr)
         z = ZONE_UP;
      else if (defl < -thr)
         z = ZONE_DOWN;
      else
         z = ZONE_CENTRE;

      if (z != cur_zone) begin
         cur_zone   = z;
         zone_t0    = now;
         first_done = 1'b0;
      end

      if (cur_zone != ZONE_CENTRE) begin
         if (!first_done) begin
            elapsed = now - zone_t0;
            if (elapsed >= {16'd0, cfg.edge_hold_ms}) begin
               res.direction_event = cur_zone;
               first_done = 1'b1;
               last_evt_t = now;
            end
         end else begin
            elapsed = now - last_evt_t;
            if (elapsed >= {16'd0, cfg.repeat_period_ms}) begin
               res.direction_event = cur_zone;
               last_evt_t = now;
            end
         end
      end

      if (btn && !btn_held) begin
         btn_held   = 1'b1;
         press_t0   = now;
         long_fired = 1'b0;
      end else if (btn && btn_held) begin
         elapsed = now - press_t0;
         if (!long_fired && elapsed >= {16'd0, cfg.long_press_ms}) begin
            res.long_press = 1'b1;
            long_fired = 1'b1;
         end
      end else if (!btn && btn_held) begin
         btn_held = 1'b0;
         if (!long_fired)
            res.short_press = 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------- stimulus

   // Mostly short gaps, some medium, a few long
   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Send one tick; valid stays high afterwards unless the next call idles
   task automatic send_tick(logic [SAMPLE_BITS-1:0] axis, logic btn, logic [TIME_BITS-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_BITS - SAMPLE_BITS - 1 - TIME_BITS){1'b0}}, now, btn, axis};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(qualify_tick(axis, btn, now));
   endtask

   // Stop sending and wait until every result has come back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [MS_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      shadow_write(idx, data);
   endtask

   task automatic apply_cfg(cfg_type c);
      write_csr(REG_CENTER_LEVEL,  16'(c.center_level));
      write_csr(REG_ENTER_THR,     16'(c.enter_threshold));
      write_csr(REG_RETURN_THR,    16'(c.return_threshold));
      write_csr(REG_INVERT,        16'(c.invert_axis));
      write_csr(REG_EDGE_HOLD,     c.edge_hold_ms);
      write_csr(REG_REPEAT_PERIOD, c.repeat_period_ms);
      write_csr(REG_LONG_PRESS,    c.long_press_ms);
      csr_valid <= 1'b0;
   endtask

   // Axis sample aimed at a class: centre, up, down, hysteresis band, noise
   function automatic logic [SAMPLE_BITS-1:0] gen_axis(int kind);
      int c, e, r, lo, hi, s;
      c = int'(cfg.center_level);
      e = int'(cfg.enter_threshold);
      r = int'(cfg.return_threshold);
      lo = (e < r) ? e : r;
      hi = (e < r) ? r : e;
      case (kind)
         0: s = c + int'($urandom_range(0, 40)) - 20;
         1: s = c + e + 1 + int'($urandom_range(0, 200));
         2: s = c - e - 1 - int'($urandom_range(0, 200));
         3: begin
            s = lo + int'($urandom_range(0, hi - lo + 1));
            s = $urandom_range(0, 1) ? c + s : c - s;
         end
         default: s = int'($urandom_range(0, 4095));
      endcase
      if (s < 0)
         s = 0;
      if (s > 4095)
         s = 4095;
      return s[SAMPLE_BITS-1:0];
   endfunction

   // Time step scaled to the current timing registers so that holds get crossed
   function automatic logic [TIME_BITS-1:0] pick_step();
      int unsigned base, r;
      base = cfg.edge_hold_ms;
      if (cfg.repeat_period_ms > base)
         base = cfg.repeat_period_ms;
      if (cfg.long_press_ms > base)
         base = cfg.long_press_ms;
      r = $urandom_range(0, 99);
      if (r < 50)
         return $urandom_range(0, base / 8 + 2);
      if (r < 85)
         return $urandom_range(0, base / 3 + 2);
      if (r < 97)
         return $urandom_range(base / 2, base + base / 4 + 2);
      return $urandom;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.center_level     = CENTER_BITS'($urandom_range(1500, 2600));
      c.enter_threshold  = THR_BITS'($urandom_range(50, 800));
      c.return_threshold = THR_BITS'((int'(c.enter_threshold) * 3) / 5);
      c.invert_axis      = 1'($urandom_range(0, 1));
      c.edge_hold_ms     = MS_BITS'($urandom_range(0, 100));
      c.repeat_period_ms = MS_BITS'($urandom_range(0, 400));
      c.long_press_ms    = MS_BITS'($urandom_range(0, 1500));
      return c;
   endfunction

   // Segments of stable deflection and button level, with some bounce
   task automatic run_phase(cfg_type c, int n_ticks);
      int   sent, seg_len, kind, r;
      logic btn;
      quiesce();
      apply_cfg(c);
      now_ms_cur = $urandom;
      sent = 0;
      while (sent < n_ticks) begin
         no_idle = (sent < 25);
         r = $urandom_range(0, 99);
         kind = (r < 30) ? 0 : (r < 55) ? 1 : (r < 80) ? 2 : (r < 90) ? 3 : 4;
         seg_len = $urandom_range(1, 12);
         btn = $urandom_range(0, 1);
         repeat (seg_len) begin
            if ($urandom_range(0, 99) < 12)
               btn = ~btn;
            now_ms_cur = now_ms_cur + pick_step();
            send_tick(gen_axis(kind), btn, now_ms_cur);
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Reset registers: hold, repeat, hysteresis, short and long press, wrap
   task automatic test_default_directed();
      send_tick(12'd2048, 1'b0, 32'd0);
      send_tick(12'd4095, 1'b0, 32'd10);
      send_tick(12'd4095, 1'b0, 32'd60);
      send_tick(12'd2348, 1'b0, 32'd100);
      send_tick(12'd2348, 1'b0, 32'd360);
      send_tick(12'd2248, 1'b0, 32'd370);
      send_tick(12'd2348, 1'b0, 32'd380);
      send_tick(12'd0,    1'b0, 32'd400);
      send_tick(12'd0,    1'b0, 32'd450);
      send_tick(12'd2048, 1'b1, 32'd500);
      send_tick(12'd2048, 1'b1, 32'd600);
      send_tick(12'd2048, 1'b0, 32'd650);
      send_tick(12'd2048, 1'b1, 32'd700);
      send_tick(12'd2048, 1'b1, 32'd1700);
      send_tick(12'd2048, 1'b1, 32'd1800);
      send_tick(12'd2048, 1'b0, 32'd1900);
      send_tick(12'd2048, 1'b1, 32'hFFFF_FF00);
      send_tick(12'd4095, 1'b1, 32'hFFFF_FFFF);
      send_tick(12'd4095, 1'b1, 32'h0000_02F0);
      send_tick(12'd4095, 1'b0, 32'h0000_0300);
   endtask

   // Unmapped index ignored, oversized values truncated to register width
   task automatic test_register_masking();
      quiesce();
      write_csr(REG_UNMAPPED,     16'hFFFF);
      write_csr(REG_CENTER_LEVEL, 16'hF800);
      write_csr(REG_ENTER_THR,    16'hF864);
      write_csr(REG_RETURN_THR,   16'hF83C);
      write_csr(REG_INVERT,       16'hFFFE);
      csr_valid <= 1'b0;
      send_tick(12'd2048, 1'b0, 32'd5000);
      send_tick(12'd2198, 1'b0, 32'd5010);
      send_tick(12'd2198, 1'b0, 32'd5100);
      send_tick(12'd2118, 1'b0, 32'd5200);
      send_tick(12'd1898, 1'b0, 32'd5300);
   endtask

   // Zero hold, repeat and long-press times
   task automatic test_zero_timing();
      cfg_type c;
      c.center_level     = 12'd2048;
      c.enter_threshold  = 11'd100;
      c.return_threshold = 11'd60;
      c.invert_axis      = 1'b1;
      c.edge_hold_ms     = 16'd0;
      c.repeat_period_ms = 16'd0;
      c.long_press_ms    = 16'd0;
      quiesce();
      apply_cfg(c);
      send_tick(12'd1548, 1'b0, 32'd100);
      send_tick(12'd1548, 1'b1, 32'd100);
      send_tick(12'd1548, 1'b1, 32'd100);
      send_tick(12'd2048, 1'b0, 32'd101);
      send_tick(12'd2048, 1'b1, 32'd102);
      send_tick(12'd2548, 1'b0, 32'd102);
   endtask

   task automatic test_random_phases();
      cfg_type c;
      // reset values again
      c.center_level     = 12'd2048;
      c.enter_threshold  = 11'd400;
      c.return_threshold = 11'd240;
      c.invert_axis      = 1'b0;
      c.edge_hold_ms     = 16'd50;
      c.repeat_period_ms = 16'd300;
      c.long_press_ms    = 16'd1000;
      run_phase(c, 150);
      repeat (3) run_phase(random_cfg(), 150);
      // minimum values in every register but the inversion bit
      c.center_level     = 12'd0;
      c.enter_threshold  = 11'd0;
      c.return_threshold = 11'd0;
      c.invert_axis      = 1'b1;
      c.edge_hold_ms     = 16'd0;
      c.repeat_period_ms = 16'd0;
      c.long_press_ms    = 16'd0;
      run_phase(c, 100);
      // maximum values in every register but the inversion bit
      c.center_level     = 12'd4095;
      c.enter_threshold  = 11'd2047;
      c.return_threshold = 11'd2047;
      c.invert_axis      = 1'b0;
      c.edge_hold_ms     = 16'hFFFF;
      c.repeat_period_ms = 16'hFFFF;
      c.long_press_ms    = 16'hFFFF;
      run_phase(c, 100);
      // return threshold above enter threshold
      c.center_level     = 12'd2048;
      c.enter_threshold  = 11'd100;
      c.return_threshold = 11'd1500;
      c.invert_axis      = 1'b1;
      c.edge_hold_ms     = 16'd20;
      c.repeat_period_ms = 16'd80;
      c.long_press_ms    = 16'd250;
      run_phase(c, 100);
   endtask

   // ------------------------------------------------------------- sequence

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_CENTER_LEVEL;
      csr_data   <= '0;
      no_idle        = 1'b0;
      run_done       = 1'b0;
      mismatch_count = 0;
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_directed();
      test_register_masking();
      test_zero_timing();
      test_random_phases();

      quiesce();
      run_done = 1'b1;
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if (!rsp_tready || no_idle) begin
         rsp_tready <= 1'b1;
         ready_hold = $urandom_range(0, 12);
      end else begin
         ready_hold = pick_gap();
         if (ready_hold > 0) begin
            rsp_tready <= 1'b0;
            ready_hold = ready_hold - 1;
         end
      end
   end

   // ------------------------------------------------------------- checking

   task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Compare each result transfer with the oldest pending tick
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result 0x%02h with no tick pending", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            check_field("direction_event", {2'b00, want.direction_event}, {2'b00, rsp_tdata[1:0]});
            check_field("short_press", {3'b000, want.short_press}, {3'b000, rsp_tdata[2]});
            check_field("long_press", {3'b000, want.long_press}, {3'b000, rsp_tdata[3]});
            check_field("pad", 4'd0, rsp_tdata[7:4]);
         end
      end
   end

   // Watchdog: too long without any transfer
   always @(posedge clock) begin
      if (reset || run_done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
